// ===== rtl/ipv4_udp_receive_parser_defines.svh =====
// Assertion macros shared by the IPv4/UDP receive parser checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef IPV4_UDP_RECEIVE_PARSER_DEFINES_SVH
`define IPV4_UDP_RECEIVE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IUPR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iupr assertion failed");

// Next-cycle implication, disabled while reset is high.
`define IUPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iupr assertion failed");

`endif

// ===== rtl/iupr_pkg.sv =====
// Types and constants for the IPv4/UDP receive parser.
// Depends on nothing; used by the parser modules, the top level and the checker.
`default_nettype none

package iupr_pkg;

   localparam int unsigned MaxPacketBytesDefault = 65535;
   localparam int unsigned CountWidth = 16;

   localparam logic [3:0] IpVersion = 4'd4;
   localparam logic [7:0] UdpProto  = 8'd17;
   localparam logic [5:0] IpHdrMin  = 6'd20;
   localparam logic [4:0] UdpHdr    = 5'd8;

   typedef enum logic [2:0] {
      STATUS_OK             = 3'd0,
      STATUS_SHORT_HEADER   = 3'd1,
      STATUS_BAD_VERSION    = 3'd2,
      STATUS_NOT_UDP        = 3'd3,
      STATUS_BAD_IHL        = 3'd4,
      STATUS_SHORT_UDP      = 3'd5,
      STATUS_BAD_UDP_LENGTH = 3'd6,
      STATUS_TRUNCATED      = 3'd7
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic        last_of_run;
      status_type  status;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [15:0] payload_length;
   } result_type;

   // Up to two results caused by one packet byte, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      result_type head_item;
      result_type tail_item;
   } result_pair_type;

endpackage

`default_nettype wire

// ===== rtl/iupr_if.sv =====
// Valid/ready channel interfaces for packet bytes in and parser results out.
// Depends on nothing outside this file.
`default_nettype none

interface iupr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;

   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface iupr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic        last_of_run;
   logic [2:0]  status;
   logic [31:0] source_address;
   logic [31:0] destination_address;
   logic [15:0] source_port;
   logic [15:0] destination_port;
   logic [15:0] payload_length;

   modport source (
      output valid, output kind, output payload_byte, output last_of_run,
      output status, output source_address, output destination_address,
      output source_port, output destination_port, output payload_length,
      input ready
   );
   modport sink (
      input valid, input kind, input payload_byte, input last_of_run,
      input status, input source_address, input destination_address,
      input source_port, input destination_port, input payload_length,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/iupr_parse.sv =====
// Byte counter, header field capture, payload forwarding and status decode.
// Depends on iupr_pkg.
`default_nettype none

module iupr_parse
   import iupr_pkg::*;
#(
   parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            commit,
   input  logic [7:0]      data_byte,
   input  logic            end_of_packet,
   output result_pair_type results
);

   logic [CountWidth-1:0] byte_count_ff, byte_count_in;
   logic [7:0]            first_byte_ff, first_byte_in;
   logic [7:0]            protocol_ff, protocol_in;
   logic [15:0]           udp_length_ff, udp_length_in;
   logic [31:0]           src_addr_ff, src_addr_in;
   logic [31:0]           dst_addr_ff, dst_addr_in;
   logic [15:0]           src_port_ff, src_port_in;
   logic [15:0]           dst_port_ff, dst_port_in;

   logic                  live;
   logic [7:0]            fb;
   logic [5:0]            hlen;
   logic [16:0]           pos_x;
   logic [16:0]           hlen_x;
   logic [CountWidth-1:0] count_next;
   logic                  forward;
   logic [16:0]           size_x;
   logic [16:0]           hlen_s_x;
   status_type            status;
   result_type            payload_res;
   result_type            summary_res;

   // Capture fields at their byte positions while the counter has not saturated.
   always_comb begin
      live   = byte_count_ff < CountWidth'(MAX_PACKET_BYTES);
      fb     = (byte_count_ff == '0) ? data_byte : first_byte_ff;
      hlen   = {fb[3:0], 2'b00};
      pos_x  = {1'b0, byte_count_ff};
      hlen_x = {11'd0, hlen};

      first_byte_in = first_byte_ff;
      protocol_in   = protocol_ff;
      udp_length_in = udp_length_ff;
      src_addr_in   = src_addr_ff;
      dst_addr_in   = dst_addr_ff;
      src_port_in   = src_port_ff;
      dst_port_in   = dst_port_ff;

      if (live) begin
         if (pos_x == 17'd0) first_byte_in = data_byte;
         if (pos_x == 17'd9) protocol_in = data_byte;
         if (pos_x >= 17'd12 && pos_x < 17'd16) src_addr_in = {src_addr_ff[23:0], data_byte};
         if (pos_x >= 17'd16 && pos_x < 17'd20) dst_addr_in = {dst_addr_ff[23:0], data_byte};
         if (pos_x == hlen_x) src_port_in = {data_byte, 8'd0};
         if (pos_x == hlen_x + 17'd1) src_port_in = {src_port_ff[15:8], data_byte};
         if (pos_x == hlen_x + 17'd2) dst_port_in = {data_byte, 8'd0};
         if (pos_x == hlen_x + 17'd3) dst_port_in = {dst_port_ff[15:8], data_byte};
         if (pos_x == hlen_x + 17'd4) udp_length_in = {data_byte, 8'd0};
         if (pos_x == hlen_x + 17'd5) udp_length_in = {udp_length_ff[15:8], data_byte};
      end

      forward = live && (first_byte_in[7:4] == IpVersion) && (protocol_in == UdpProto)
                && (hlen >= IpHdrMin) && (pos_x >= hlen_x + 17'(UdpHdr))
                && (pos_x < hlen_x + {1'b0, udp_length_in});

      count_next    = live ? byte_count_ff + CountWidth'(1) : byte_count_ff;
      byte_count_in = end_of_packet ? '0 : count_next;
   end

   // Summary status: the first failing check wins.
   always_comb begin
      size_x   = {1'b0, count_next};
      hlen_s_x = {11'd0, first_byte_in[3:0], 2'b00};
      if (size_x < 17'(IpHdrMin)) begin
         status = STATUS_SHORT_HEADER;
      end else if (first_byte_in[7:4] != IpVersion) begin
         status = STATUS_BAD_VERSION;
      end else if (protocol_in != UdpProto) begin
         status = STATUS_NOT_UDP;
      end else if (hlen_s_x < 17'(IpHdrMin)) begin
         status = STATUS_BAD_IHL;
      end else if (size_x < hlen_s_x + 17'(UdpHdr)) begin
         status = STATUS_SHORT_UDP;
      end else if (udp_length_in < 16'(UdpHdr)) begin
         status = STATUS_BAD_UDP_LENGTH;
      end else if (hlen_s_x + {1'b0, udp_length_in} > size_x) begin
         status = STATUS_TRUNCATED;
      end else begin
         status = STATUS_OK;
      end
   end

   // Build the forwarded byte and the summary; the summary always comes last.
   always_comb begin
      payload_res              = '0;
      payload_res.kind         = KIND_PAYLOAD;
      payload_res.payload_byte = data_byte;
      payload_res.last_of_run  = !end_of_packet;
      payload_res.status       = STATUS_OK;

      summary_res             = '0;
      summary_res.kind        = KIND_SUMMARY;
      summary_res.last_of_run = 1'b1;
      summary_res.status      = status;
      if (status == STATUS_OK) begin
         summary_res.source_address      = src_addr_in;
         summary_res.destination_address = dst_addr_in;
         summary_res.source_port         = src_port_in;
         summary_res.destination_port    = dst_port_in;
         summary_res.payload_length      = udp_length_in - 16'(UdpHdr);
      end

      results.count     = {1'b0, forward} + {1'b0, end_of_packet};
      results.head_item = forward ? payload_res : summary_res;
      results.tail_item = summary_res;
   end

   // State advances once per byte taken from the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         first_byte_ff <= '0;
         protocol_ff   <= '0;
         udp_length_ff <= '0;
         src_addr_ff   <= '0;
         dst_addr_ff   <= '0;
         src_port_ff   <= '0;
         dst_port_ff   <= '0;
      end else if (commit) begin
         byte_count_ff <= byte_count_in;
         first_byte_ff <= first_byte_in;
         protocol_ff   <= protocol_in;
         udp_length_ff <= udp_length_in;
         src_addr_ff   <= src_addr_in;
         dst_addr_ff   <= dst_addr_in;
         src_port_ff   <= src_port_in;
         dst_port_ff   <= dst_port_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/iupr_rsp_buf.sv =====
// Two-entry result buffer that takes up to two results in one cycle.
// Depends on iupr_pkg.
`default_nettype none

module iupr_rsp_buf
   import iupr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  result_pair_type pair,
   output logic            can_take,
   output logic            out_valid,
   input  logic            out_ready,
   output result_type      out_item
);

   logic [1:0] count_ff, count_in;
   result_type head_ff, head_in;
   result_type tail_ff, tail_in;
   logic       pop;
   logic [1:0] remain;
   logic [1:0] push_n;

   // Room check counts the entry leaving this cycle.
   always_comb begin
      pop      = (count_ff != 2'd0) && out_ready;
      remain   = count_ff - {1'b0, pop};
      can_take = ({1'b0, remain} + {1'b0, pair.count}) <= 3'd2;
      push_n   = push ? pair.count : 2'd0;
      count_in = remain + push_n;
   end

   // Shift the tail forward on a transfer, then append new results.
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      case (remain)
         2'd0: begin
            head_in = pair.head_item;
            tail_in = pair.tail_item;
         end
         2'd1: begin
            head_in = pop ? tail_ff : head_ff;
            tail_in = pair.head_item;
         end
         default: begin
            head_in = head_ff;
            tail_in = tail_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign out_valid = count_ff != 2'd0;
   assign out_item  = head_ff;

endmodule

`default_nettype wire

// ===== rtl/ipv4_udp_receive_parser.sv =====
// Top level of the IPv4/UDP receive parser.
// Depends on iupr_pkg, iupr_if, iupr_parse and iupr_rsp_buf.
//
//   Channel    Direction  Carries
//   req_chan   in         one packet byte, end-of-packet flag
//   rsp_chan   out        forwarded payload byte or end-of-packet summary
//
// One byte is taken per cycle while the buffer has room; a byte is held in the
// input register and its results are then registered in a two-entry output buffer.
// A final byte inside the payload range makes two results, which leave the
// buffer in turn; the input register waits only while the buffer lacks room.
// Reset is synchronous and clears the byte counter, captures and buffers.
// A stalled result side backs up through the buffer to req_chan.ready.
`default_nettype none

module ipv4_udp_receive_parser
   import iupr_pkg::*;
#(
   parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   iupr_req_if.sink   req_chan,
   iupr_rsp_if.source rsp_chan
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_eop_ff;
   logic            req_xfer;
   logic            advance;
   logic            can_take;
   result_pair_type pair;
   result_type      out_item;

   // The held byte moves on when the buffer has room for all its results.
   assign advance        = in_valid_ff && can_take;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_chan.data_byte;
         in_eop_ff  <= req_chan.end_of_packet;
      end
   end

   iupr_parse #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .commit        (advance),
      .data_byte     (in_byte_ff),
      .end_of_packet (in_eop_ff),
      .results       (pair)
   );

   iupr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .pair      (pair),
      .can_take  (can_take),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   // Result channel payload.
   assign rsp_chan.kind                = out_item.kind;
   assign rsp_chan.payload_byte        = out_item.payload_byte;
   assign rsp_chan.last_of_run         = out_item.last_of_run;
   assign rsp_chan.status              = out_item.status;
   assign rsp_chan.source_address      = out_item.source_address;
   assign rsp_chan.destination_address = out_item.destination_address;
   assign rsp_chan.source_port         = out_item.source_port;
   assign rsp_chan.destination_port    = out_item.destination_port;
   assign rsp_chan.payload_length      = out_item.payload_length;

endmodule

`default_nettype wire

// ===== rtl/iupr_check.sv =====
// Port-level checks for the IPv4/UDP receive parser, bound to the top level.
// Depends on iupr_pkg and ipv4_udp_receive_parser_defines.svh.
`default_nettype none
`include "ipv4_udp_receive_parser_defines.svh"

module iupr_check
   import iupr_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_kind,
   input wire logic [7:0]  rsp_payload_byte,
   input wire logic        rsp_last_of_run,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_source_address,
   input wire logic [15:0] rsp_payload_length
);

   // A stalled result stays offered with the same payload byte.
   `IUPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `IUPR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload_byte) && $stable(rsp_kind))

   // A summary always closes the run of results for its byte.
   `IUPR_ASSERT_IMPLY(a_sum_last, clock, reset, rsp_valid && rsp_kind == KIND_SUMMARY, rsp_last_of_run)

   // A failed packet reports no captured fields.
   `IUPR_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid && rsp_kind == KIND_SUMMARY && rsp_status != STATUS_OK, rsp_payload_length == 16'd0 && rsp_source_address == 32'd0)

   // Forwarded bytes carry no status.
   `IUPR_ASSERT_IMPLY(a_pay_status, clock, reset, rsp_valid && rsp_kind == KIND_PAYLOAD, rsp_status == STATUS_OK)

endmodule

bind ipv4_udp_receive_parser iupr_check u_iupr_check (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_kind           (rsp_chan.kind),
   .rsp_payload_byte   (rsp_chan.payload_byte),
   .rsp_last_of_run    (rsp_chan.last_of_run),
   .rsp_status         (rsp_chan.status),
   .rsp_source_address (rsp_chan.source_address),
   .rsp_payload_length (rsp_chan.payload_length)
);

`default_nettype wire
